// ===== src/bsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

  // Size limits used as parameter defaults
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Header layout
  localparam int          HDR_LEN  = 54;
  localparam logic [5:0]  HDR_LAST = 6'(HDR_LEN - 1);
  localparam int          HB_LEN   = 34;    // bytes 0..33 carry every field we check
  localparam logic [7:0]  MAGIC_B  = 8'h42;
  localparam logic [7:0]  MAGIC_M  = 8'h4D;
  localparam logic [31:0] DIB_MIN  = 32'd40;
  localparam logic [15:0] BPP_24   = 16'd24;
  localparam logic [15:0] BPP_32   = 16'd32;

  // Final status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_TRUNC  = 3'd1;
  localparam logic [2:0] ST_MAGIC  = 3'd2;
  localparam logic [2:0] ST_FORMAT = 3'd3;
  localparam logic [2:0] ST_PARSE  = 3'd4;
  localparam logic [2:0] ST_LARGE  = 3'd5;

  // Result queue depth
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [2:0]  status;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        final_res;
  } result_t;

  // Per-file pixel layout, captured when the last header byte is accepted
  typedef struct packed {
    logic       top_down;
    logic       bpp4;
    logic [1:0] pad;
  } hdr_flags_t;

endpackage

`default_nettype wire

// ===== src/bsd_hdr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_hdr #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bsd_pkg::DEF_MAX_HEIGHT
) (
  input  wire                                 clk,
  input  wire                                 wr_en,
  input  wire  [5:0]                          idx,
  input  wire  [7:0]                          data,
  input  wire                                 chk_en,
  output logic [2:0]                          err,
  output logic                                off54,
  output logic [31:0]                         offset,
  output logic [$clog2(MAX_WIDTH + 1) - 1:0]  width_r,
  output logic [$clog2(MAX_HEIGHT + 1) - 1:0] height_r,
  output bsd_pkg::hdr_flags_t                 flags_r
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [7:0]  hb_r [bsd_pkg::HB_LEN];
  logic [31:0] dib, width, height, hmag, compr;
  logic [15:0] planes, bpp;

  always_ff @(posedge clk) begin
    if (wr_en && (idx < 6'(bsd_pkg::HB_LEN))) begin
      hb_r[idx] <= data;
    end
  end

  // little-endian fields
  assign offset = {hb_r[13], hb_r[12], hb_r[11], hb_r[10]};
  assign dib    = {hb_r[17], hb_r[16], hb_r[15], hb_r[14]};
  assign width  = {hb_r[21], hb_r[20], hb_r[19], hb_r[18]};
  assign height = {hb_r[25], hb_r[24], hb_r[23], hb_r[22]};
  assign planes = {hb_r[27], hb_r[26]};
  assign bpp    = {hb_r[29], hb_r[28]};
  assign compr  = {hb_r[33], hb_r[32], hb_r[31], hb_r[30]};

  assign hmag  = height[31] ? (~height + 32'd1) : height;
  assign off54 = (offset == 32'(bsd_pkg::HDR_LEN));

  always_comb begin
    if (hb_r[0] != bsd_pkg::MAGIC_B || hb_r[1] != bsd_pkg::MAGIC_M) begin
      err = bsd_pkg::ST_MAGIC;
    end else if (dib < bsd_pkg::DIB_MIN) begin
      err = bsd_pkg::ST_FORMAT;
    end else if (planes != 16'd1 || (bpp != bsd_pkg::BPP_24 && bpp != bsd_pkg::BPP_32) ||
                 compr != 32'd0) begin
      err = bsd_pkg::ST_FORMAT;
    end else if (width == 32'd0 || width[31]) begin
      err = bsd_pkg::ST_PARSE;
    end else if (height == 32'd0) begin
      err = bsd_pkg::ST_PARSE;
    end else if (offset < 32'(bsd_pkg::HDR_LEN)) begin
      err = bsd_pkg::ST_FORMAT;
    end else if (width > 32'(MAX_WIDTH) || hmag > 32'(MAX_HEIGHT)) begin
      err = bsd_pkg::ST_LARGE;
    end else begin
      err = bsd_pkg::ST_OK;
    end
  end

  // 24 bpp rows pad to 4 bytes: pad = width mod 4; 32 bpp never pads
  always_ff @(posedge clk) begin
    if (chk_en) begin
      width_r          <= width[CW-1:0];
      height_r         <= hmag[RW-1:0];
      flags_r.top_down <= height[31];
      flags_r.bpp4     <= (bpp == bsd_pkg::BPP_32);
      flags_r.pad      <= (bpp == bsd_pkg::BPP_32) ? 2'd0 : width[1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/bsd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_parse #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bsd_pkg::DEF_MAX_HEIGHT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 acc,
  input  wire  [7:0]                          data,
  input  wire                                 eof,
  input  wire  [2:0]                          hdr_err,
  input  wire                                 off54,
  input  wire  [31:0]                         offset,
  input  wire  [$clog2(MAX_WIDTH + 1) - 1:0]  width_r,
  input  wire  [$clog2(MAX_HEIGHT + 1) - 1:0] height_r,
  input  bsd_pkg::hdr_flags_t                 flags,
  output logic                                hdr_wr,
  output logic                                chk_en,
  output logic [5:0]                          hdr_idx,
  output logic                                pix_v,
  output bsd_pkg::result_t                    pix,
  output logic                                st_v,
  output bsd_pkg::result_t                    st
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD, PH_TAIL, PH_DRAIN
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [CW-1:0] col_r, col_nxt, col_inc;
  logic [RW-1:0] row_r, row_nxt, row_inc;
  logic [1:0]    pbi_r, pbi_nxt, pbi_last;
  logic [1:0]    pad_r, pad_nxt;
  logic [23:0]   pb_r, pb_nxt;
  logic [31:0]   dst_row;

  assign hdr_idx  = pos_r[5:0];
  assign hdr_wr   = acc && (phase_r == PH_HEADER);
  assign chk_en   = hdr_wr && (pos_r[5:0] == bsd_pkg::HDR_LAST);
  assign col_inc  = CW'(col_r + 1'b1);
  assign row_inc  = RW'(row_r + 1'b1);
  assign pbi_last = flags.bpp4 ? 2'd3 : 2'd2;
  assign dst_row  = flags.top_down ? 32'(row_r) : (32'(height_r) - 32'(row_r) - 32'd1);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pbi_nxt   = pbi_r;
    pad_nxt   = pad_r;
    pb_nxt    = pb_r;
    pix_v     = 1'b0;
    pix       = '0;
    st_v      = 1'b0;
    st        = '0;
    if (acc) begin
      if (pos_r != '1) begin
        pos_nxt = pos_r + 32'd1;
      end
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r[5:0] == bsd_pkg::HDR_LAST) begin
            if (hdr_err != bsd_pkg::ST_OK) begin
              err_nxt   = hdr_err;
              phase_nxt = PH_DRAIN;
            end else begin
              phase_nxt = off54 ? PH_PIXEL : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (({1'b0, pos_r} + 33'd1) >= {1'b0, offset}) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (pbi_r != pbi_last) begin
            pb_nxt  = pb_r | (24'(data) << {pbi_r, 3'b000});
            pbi_nxt = pbi_r + 2'd1;
          end else begin
            pix_v         = 1'b1;
            pix.column    = 12'(32'(col_r));
            pix.row       = dst_row[11:0];
            pix.red       = flags.bpp4 ? pb_r[23:16] : data;
            pix.green     = pb_r[15:8];
            pix.blue      = pb_r[7:0];
            pix.alpha     = flags.bpp4 ? data : 8'd0;
            pix.has_alpha = flags.bpp4;
            pb_nxt        = '0;
            pbi_nxt       = 2'd0;
            col_nxt       = col_inc;
            if (col_inc >= width_r) begin
              if (flags.pad != 2'd0) begin
                pad_nxt   = flags.pad;
                phase_nxt = PH_PAD;
              end else begin
                col_nxt   = '0;
                row_nxt   = row_inc;
                phase_nxt = (row_inc >= height_r) ? PH_TAIL : PH_PIXEL;
              end
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            col_nxt   = '0;
            row_nxt   = row_inc;
            phase_nxt = (row_inc >= height_r) ? PH_TAIL : PH_PIXEL;
          end
        end
        PH_TAIL, PH_DRAIN: begin
        end
        default: begin
        end
      endcase
      if (eof) begin
        st_v         = 1'b1;
        st.kind      = 1'b1;
        st.final_res = 1'b1;
        if (phase_nxt == PH_DRAIN) begin
          st.status = err_nxt;
        end else if (phase_nxt == PH_TAIL) begin
          st.status       = bsd_pkg::ST_OK;
          st.image_width  = 13'(32'(width_r));
          st.image_height = 13'(32'(height_r));
        end else begin
          st.status = bsd_pkg::ST_TRUNC;
        end
        // next byte starts a new file
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        err_nxt   = bsd_pkg::ST_OK;
        col_nxt   = '0;
        row_nxt   = '0;
        pbi_nxt   = 2'd0;
        pad_nxt   = 2'd0;
        pb_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      err_r   <= bsd_pkg::ST_OK;
      col_r   <= '0;
      row_r   <= '0;
      pbi_r   <= 2'd0;
      pad_r   <= 2'd0;
      pb_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pbi_r   <= pbi_nxt;
      pad_r   <= pad_nxt;
      pb_r    <= pb_nxt;
    end
  end

  a_status_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    st_v |=> (phase_r == PH_HEADER && pos_r == 32'd0 && row_r == '0))
    else $error("state not cleared after status item");

  a_pbi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXEL && !flags.bpp4) |-> (pbi_r != 2'd3))
    else $error("pixel byte index past 24 bpp pixel");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAD) |-> (pad_r != 2'd0))
    else $error("padding phase with no bytes left");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    pix_v |-> (col_r < width_r))
    else $error("pixel column beyond image width");

endmodule

`default_nettype wire

// ===== src/bsd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_outq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     p0_v,
  input  bsd_pkg::result_t        p0,
  input  wire                     p1_v,
  input  bsd_pkg::result_t        p1,
  output logic                    room,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bsd_pkg::result_t        out_res
);

  localparam int AW = $clog2(bsd_pkg::OQ_DEPTH);

  bsd_pkg::result_t q_r [bsd_pkg::OQ_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r, wp1;
  logic [AW:0]   cnt_r, free_after;
  logic          pop;
  logic [1:0]    n_push;

  assign out_valid  = (cnt_r != '0);
  assign out_res    = q_r[rptr_r];
  assign pop        = out_valid && out_ready;
  assign n_push     = {1'b0, p0_v} + {1'b0, p1_v};
  assign wp1        = p0_v ? AW'(wptr_r + 1'b1) : wptr_r;
  assign free_after = (AW + 1)'(bsd_pkg::OQ_DEPTH) - cnt_r + (AW + 1)'(pop);
  // an input byte can yield two items
  assign room       = (free_after >= (AW + 1)'(2));

  always_ff @(posedge clk) begin
    for (int i = 0; i < bsd_pkg::OQ_DEPTH; i++) begin
      if (p0_v && wptr_r == AW'(i)) begin
        q_r[i] <= p0;
      end else if (p1_v && wp1 == AW'(i)) begin
        q_r[i] <= p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= AW'(wptr_r + n_push);
      rptr_r <= AW'(rptr_r + (AW + 1)'(pop));
      cnt_r  <= cnt_r + (AW + 1)'(n_push) - (AW + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(bsd_pkg::OQ_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== src/bmp_stream_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+------------------------------
// in       | in_valid/in_ready, in_data_byte,        | one file byte per item
//          | in_end_of_file                          |
// out      | out_valid/out_ready, out_kind ...       | one pixel or final status
//          | out_final_res                           | item
//
// One byte item is taken per clock while in_ready is high; parser state and the
// result queue both update in that same cycle, so a result can appear on out_* the
// cycle after its byte is accepted. The byte that ends the file can yield a pixel and
// the status item; in_ready stays high while the 4-entry result queue has room for
// two items after this cycle's pop. Synchronous active-low reset returns the parser
// to the header phase and empties the queue; no clearing pass is needed. Stalls on
// out_ready back up into in_ready only once three items wait.

module bmp_stream_decoder_top #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bsd_pkg::DEF_MAX_HEIGHT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_end_of_file,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_kind,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_has_alpha,
  output logic [2:0]  out_status,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic        out_final_res
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic                acc;
  logic                hdr_wr, chk_en, off54;
  logic [5:0]          hdr_idx;
  logic [2:0]          hdr_err;
  logic [31:0]         offset;
  logic [CW-1:0]       width_r;
  logic [RW-1:0]       height_r;
  bsd_pkg::hdr_flags_t flags;
  logic                pix_v, st_v;
  bsd_pkg::result_t    pix, st, res;

  assign acc = in_valid && in_ready;

  // header capture and validation
  bsd_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk      (clk),
    .wr_en    (hdr_wr),
    .idx      (hdr_idx),
    .data     (in_data_byte),
    .chk_en   (chk_en),
    .err      (hdr_err),
    .off54    (off54),
    .offset   (offset),
    .width_r  (width_r),
    .height_r (height_r),
    .flags_r  (flags)
  );

  // phase tracking, pixel assembly, row/column counting
  bsd_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .data     (in_data_byte),
    .eof      (in_end_of_file),
    .hdr_err  (hdr_err),
    .off54    (off54),
    .offset   (offset),
    .width_r  (width_r),
    .height_r (height_r),
    .flags    (flags),
    .hdr_wr   (hdr_wr),
    .chk_en   (chk_en),
    .hdr_idx  (hdr_idx),
    .pix_v    (pix_v),
    .pix      (pix),
    .st_v     (st_v),
    .st       (st)
  );

  // pixel goes ahead of the status item when both come from one byte
  bsd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .p0_v      (pix_v),
    .p0        (pix),
    .p1_v      (st_v),
    .p1        (st),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_column       = res.column;
  assign out_row          = res.row;
  assign out_red          = res.red;
  assign out_green        = res.green;
  assign out_blue         = res.blue;
  assign out_alpha        = res.alpha;
  assign out_has_alpha    = res.has_alpha;
  assign out_status       = res.status;
  assign out_image_width  = res.image_width;
  assign out_image_height = res.image_height;
  assign out_final_res    = res.final_res;

endmodule

`default_nettype wire
